### design/hierarchical_z_pyramid_assert.svh
// Assertion macros for the depth pyramid.
`ifndef HIERARCHICAL_Z_PYRAMID_ASSERT_SVH
`define HIERARCHICAL_Z_PYRAMID_ASSERT_SVH

`ifndef SYNTHESIS
`define HZP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HZP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HZP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define HZP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/hzp_pkg.sv
`default_nettype none

package hzp_pkg;

    localparam int OP_W    = 2;
    localparam int COORD_W = 9;
    localparam int DEPTH_W = 24;
    localparam int LEVEL_W = 4;

    localparam int SIDE_LOG2_DEF  = 9;
    localparam int DEPTH_BITS_DEF = 24;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

endpackage

`default_nettype wire

### design/hzp_cmd_if.sv
`default_nettype none

interface hzp_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [hzp_pkg::OP_W-1:0]            op;
    logic [hzp_pkg::COORD_W-1:0]         x_first;
    logic [hzp_pkg::COORD_W-1:0]         y_first;
    logic [hzp_pkg::COORD_W-1:0]         x_last;
    logic [hzp_pkg::COORD_W-1:0]         y_last;
    logic signed [hzp_pkg::DEPTH_W-1:0]  depth;

    modport source (
        output valid, op, x_first, y_first, x_last, y_last, depth,
        input  ready
    );

    modport sink (
        input  valid, op, x_first, y_first, x_last, y_last, depth,
        output ready
    );
endinterface

`default_nettype wire

### design/hzp_res_if.sv
`default_nettype none

interface hzp_res_if;
    logic                                valid;
    logic                                ready;
    logic                                passed;
    logic signed [hzp_pkg::DEPTH_W-1:0]  node_depth;
    logic [hzp_pkg::LEVEL_W-1:0]         node_level;

    modport source (
        output valid, passed, node_depth, node_level,
        input  ready
    );

    modport sink (
        input  valid, passed, node_depth, node_level,
        output ready
    );
endinterface

`default_nettype wire

### design/hierarchical_z_pyramid.sv
// Write: leaf quad read, then each level climbed writes its quad back and reads the parent.
// Query: one quad read per query, none when only the root encloses the box (root is a register).
// Clear: one quad written per cycle, all (4**SIDE_LOG2 - 1) / 3 quads (87381 at SIDE_LOG2 = 9).
// One item in flight; the next is taken the cycle after its result reaches the output register.
// Reset: asynchronous, active low; sweeps the block store to far as a clear does, no
// transfer is taken on cmd until the sweep ends.
`default_nettype none

module hierarchical_z_pyramid #(
    parameter int SIDE_LOG2  = hzp_pkg::SIDE_LOG2_DEF,
    parameter int DEPTH_BITS = hzp_pkg::DEPTH_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hzp_cmd_if.sink    cmd,
    hzp_res_if.source  res
);

    localparam int BADDR_W = 2 * SIDE_LOG2 - 1;
    localparam int WORD_W  = 4 * DEPTH_BITS;
    localparam int BLOCKS  = ((4 ** SIDE_LOG2) - 1) / 3;

    logic               mem_wr_en;
    logic [BADDR_W-1:0] mem_wr_addr;
    logic [WORD_W-1:0]  mem_wr_data;
    logic               mem_rd_en;
    logic [BADDR_W-1:0] mem_rd_addr;
    logic [WORD_W-1:0]  mem_rd_data;

    hzp_ctrl #(
        .SIDE_LOG2  (SIDE_LOG2),
        .DEPTH_BITS (DEPTH_BITS),
        .BADDR_W    (BADDR_W),
        .WORD_W     (WORD_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    hzp_mem #(
        .WORD_W  (WORD_W),
        .ENTRIES (BLOCKS),
        .ADDR_W  (BADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

### design/hzp_mem.sv
`default_nettype none

// Block store: one word holds the four siblings of a 2x2 quad.
module hzp_mem #(
    parameter int WORD_W  = 96,
    parameter int ENTRIES = 87381,
    parameter int ADDR_W  = 17
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WORD_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [ENTRIES];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/hzp_ctrl.sv
`default_nettype none
`include "hierarchical_z_pyramid_assert.svh"

module hzp_ctrl #(
    parameter int SIDE_LOG2  = hzp_pkg::SIDE_LOG2_DEF,
    parameter int DEPTH_BITS = hzp_pkg::DEPTH_BITS_DEF,
    parameter int BADDR_W    = 2 * SIDE_LOG2 - 1,
    parameter int WORD_W     = 4 * DEPTH_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    hzp_cmd_if.sink                 cmd,
    hzp_res_if.source               res,
    output logic                    mem_wr_en,
    output logic [BADDR_W-1:0]      mem_wr_addr,
    output logic [WORD_W-1:0]       mem_wr_data,
    output logic                    mem_rd_en,
    output logic [BADDR_W-1:0]      mem_rd_addr,
    input  wire logic [WORD_W-1:0]  mem_rd_data
);

    localparam int LVL_W   = $clog2(SIDE_LOG2 + 1);
    localparam int BLOCKS  = ((4 ** SIDE_LOG2) - 1) / 3;
    localparam int EXT_W   = (DEPTH_BITS > hzp_pkg::DEPTH_W) ? DEPTH_BITS : hzp_pkg::DEPTH_W;
    localparam int CEXT_W  = (SIDE_LOG2 > hzp_pkg::COORD_W) ? SIDE_LOG2 : hzp_pkg::COORD_W;
    localparam logic [LVL_W-1:0]   LEAF_LVL  = LVL_W'(SIDE_LOG2);
    localparam logic [BADDR_W-1:0] LAST_BLK  = BADDR_W'(BLOCKS - 1);
    localparam logic signed [DEPTH_BITS-1:0] FAR_DEPTH  = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] NEAR_DEPTH = {1'b0, {(DEPTH_BITS-1){1'b1}}};

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_QPREP,
        S_ISSUE,
        S_LEAF,
        S_CLIMB,
        S_QREAD,
        S_ROOT,
        S_DONE
    } state_t;

    // control
    state_t                   state_reg, state_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DEPTH_BITS-1:0] root_reg, root_next;
    logic [BADDR_W-1:0]       clr_addr_reg, clr_addr_next;
    logic                     clr_op_reg, clr_op_next;

    // payload
    hzp_pkg::op_t             op_reg, op_next;
    logic [SIDE_LOG2-1:0]     cx_reg, cx_next;
    logic [SIDE_LOG2-1:0]     cy_reg, cy_next;
    logic [SIDE_LOG2-1:0]     xb_reg, xb_next;
    logic [SIDE_LOG2-1:0]     yb_reg, yb_next;
    logic [LVL_W-1:0]         lvl_reg, lvl_next;
    logic [BADDR_W-1:0]       blk_addr_reg, blk_addr_next;
    logic signed [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic signed [DEPTH_BITS-1:0] m_reg, m_next;
    logic                     res_passed_reg, res_passed_next;
    logic signed [DEPTH_BITS-1:0] res_depth_reg, res_depth_next;
    logic [LVL_W-1:0]         res_level_reg, res_level_next;
    logic                     out_passed_reg, out_passed_next;
    logic signed [hzp_pkg::DEPTH_W-1:0] out_depth_reg, out_depth_next;
    logic [hzp_pkg::LEVEL_W-1:0] out_level_reg, out_level_next;

    // datapath
    logic [1:0]                   lane;
    logic signed [DEPTH_BITS-1:0] lane_val;
    logic signed [DEPTH_BITS-1:0] upd_val;
    logic [WORD_W-1:0]            upd_word;
    logic signed [DEPTH_BITS-1:0] upd_min;
    logic [SIDE_LOG2-1:0]         q_diff, q_xl, q_yl;
    logic [LVL_W-1:0]             q_span;
    logic signed [EXT_W-1:0]      d_ext;
    logic [EXT_W-DEPTH_BITS:0]    d_upper;
    logic signed [DEPTH_BITS-1:0] d_clamped;
    logic [BADDR_W-1:0]           up_addr;

    function automatic logic signed [DEPTH_BITS-1:0] get_lane(
        input logic [WORD_W-1:0] word,
        input logic [1:0]        idx
    );
        return word[idx * DEPTH_BITS +: DEPTH_BITS];
    endfunction

    function automatic logic signed [DEPTH_BITS-1:0] min2(
        input logic signed [DEPTH_BITS-1:0] a,
        input logic signed [DEPTH_BITS-1:0] b
    );
        return (b < a) ? b : a;
    endfunction

    function automatic logic [SIDE_LOG2-1:0] take_coord(
        input logic [hzp_pkg::COORD_W-1:0] v
    );
        logic [CEXT_W-1:0] e;
        e = CEXT_W'(v);
        return e[SIDE_LOG2-1:0];
    endfunction

    function automatic logic signed [hzp_pkg::DEPTH_W-1:0] to_port(
        input logic signed [DEPTH_BITS-1:0] v
    );
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[hzp_pkg::DEPTH_W-1:0];
    endfunction

    // Address of the quad that holds node (cx, cy) of level lvl (lvl >= 1):
    // the quads of levels 1..lvl-1 fill the store below it, then rows of parents.
    function automatic logic [BADDR_W-1:0] block_addr(
        input logic [LVL_W-1:0]     lvl,
        input logic [SIDE_LOG2-1:0] x,
        input logic [SIDE_LOG2-1:0] y
    );
        logic [BADDR_W-1:0] base;
        logic [BADDR_W-1:0] off;
        base = '0;
        for (int i = 0; i < SIDE_LOG2 - 1; i++)
        begin
            base[2*i] = (LVL_W'(i + 1) < lvl);
        end
        off = (BADDR_W'(y >> 1) << (lvl - 1'b1)) | BADDR_W'(x >> 1);
        return base + off;
    endfunction

    assign lane     = {cy_reg[0], cx_reg[0]};
    assign lane_val = get_lane(mem_rd_data, lane);
    assign upd_val  = (state_reg == S_LEAF) ? depth_reg : m_reg;

    always_comb
    begin
        upd_word = mem_rd_data;
        upd_word[lane * DEPTH_BITS +: DEPTH_BITS] = upd_val;
    end

    assign upd_min = min2(min2(get_lane(upd_word, 2'd0), get_lane(upd_word, 2'd1)),
                          min2(get_lane(upd_word, 2'd2), get_lane(upd_word, 2'd3)));

    assign up_addr = block_addr(lvl_reg - 1'b1, cx_reg >> 1, cy_reg >> 1);

    // saturate the incoming depth into the stored width
    assign d_ext   = EXT_W'(cmd.depth);
    assign d_upper = d_ext[EXT_W-1:DEPTH_BITS-1];
    always_comb
    begin
        if ((&d_upper) || !(|d_upper))
        begin
            d_clamped = d_ext[DEPTH_BITS-1:0];
        end
        else if (d_ext[EXT_W-1])
        begin
            d_clamped = FAR_DEPTH;
        end
        else
        begin
            d_clamped = NEAR_DEPTH;
        end
    end

    // smallest aligned node around the query box
    always_comb
    begin
        q_diff = (cx_reg ^ xb_reg) | (cy_reg ^ yb_reg);
        q_xl   = (cx_reg < xb_reg) ? cx_reg : xb_reg;
        q_yl   = (cy_reg < yb_reg) ? cy_reg : yb_reg;
        q_span = '0;
        for (int i = 0; i < SIDE_LOG2; i++)
        begin
            if (q_diff[i])
            begin
                q_span = LVL_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        root_next       = root_reg;
        clr_addr_next   = clr_addr_reg;
        clr_op_next     = clr_op_reg;
        op_next         = op_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        xb_next         = xb_reg;
        yb_next         = yb_reg;
        lvl_next        = lvl_reg;
        blk_addr_next   = blk_addr_reg;
        depth_next      = depth_reg;
        m_next          = m_reg;
        res_passed_next = res_passed_reg;
        res_depth_next  = res_depth_reg;
        res_level_next  = res_level_reg;
        out_passed_next = out_passed_reg;
        out_depth_next  = out_depth_reg;
        out_level_next  = out_level_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = blk_addr_reg;
        mem_wr_data     = upd_word;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = up_addr;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wr_data = {4{FAR_DEPTH}};
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_BLK)
                begin
                    clr_op_next = 1'b0;
                    if (clr_op_reg)
                    begin
                        res_passed_next = 1'b1;
                        res_depth_next  = FAR_DEPTH;
                        res_level_next  = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = hzp_pkg::op_t'(cmd.op);
                    cx_next    = take_coord(cmd.x_first);
                    cy_next    = take_coord(cmd.y_first);
                    xb_next    = take_coord(cmd.x_last);
                    yb_next    = take_coord(cmd.y_last);
                    depth_next = d_clamped;
                    lvl_next   = LEAF_LVL;
                    unique case (cmd.op)
                        hzp_pkg::OP_WRITE: state_next = S_ISSUE;
                        hzp_pkg::OP_QUERY: state_next = S_QPREP;
                        hzp_pkg::OP_CLEAR:
                        begin
                            root_next     = FAR_DEPTH;
                            clr_addr_next = '0;
                            clr_op_next   = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            res_passed_next = 1'b0;
                            res_depth_next  = '0;
                            res_level_next  = '0;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_QPREP:
            begin
                cx_next    = q_xl >> q_span;
                cy_next    = q_yl >> q_span;
                lvl_next   = LEAF_LVL - q_span;
                state_next = S_ISSUE;
            end

            S_ISSUE:
            begin
                if (lvl_reg == '0)
                begin
                    res_passed_next = (root_reg < depth_reg);
                    res_depth_next  = root_reg;
                    res_level_next  = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = block_addr(lvl_reg, cx_reg, cy_reg);
                    blk_addr_next = mem_rd_addr;
                    state_next    = (op_reg == hzp_pkg::OP_WRITE) ? S_LEAF : S_QREAD;
                end
            end

            S_QREAD:
            begin
                res_passed_next = (lane_val < depth_reg);
                res_depth_next  = lane_val;
                res_level_next  = lvl_reg;
                state_next      = S_DONE;
            end

            S_LEAF, S_CLIMB:
            begin
                if (state_reg == S_LEAF)
                begin
                    res_level_next  = LEAF_LVL;
                    res_passed_next = (depth_reg > lane_val);
                    res_depth_next  = (depth_reg > lane_val) ? depth_reg : lane_val;
                end
                // stop at the leaf on a failed test, above it once a node holds
                if ((state_reg == S_LEAF) ? !(depth_reg > lane_val) : (lane_val == m_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_wr_en = 1'b1;
                    m_next    = upd_min;
                    if (lvl_reg == LVL_W'(1))
                    begin
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        // fetch the parent quad while this one is written back
                        mem_rd_en     = 1'b1;
                        blk_addr_next = up_addr;
                        cx_next       = cx_reg >> 1;
                        cy_next       = cy_reg >> 1;
                        lvl_next      = lvl_reg - 1'b1;
                        state_next    = S_CLIMB;
                    end
                end
            end

            S_ROOT:
            begin
                root_next  = m_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_passed_next = res_passed_reg;
                    out_depth_next  = to_port(res_depth_reg);
                    out_level_next  = hzp_pkg::LEVEL_W'(res_level_reg);
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            root_reg      <= FAR_DEPTH;
            clr_addr_reg  <= '0;
            clr_op_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            root_reg      <= root_next;
            clr_addr_reg  <= clr_addr_next;
            clr_op_reg    <= clr_op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        xb_reg         <= xb_next;
        yb_reg         <= yb_next;
        lvl_reg        <= lvl_next;
        blk_addr_reg   <= blk_addr_next;
        depth_reg      <= depth_next;
        m_reg          <= m_next;
        res_passed_reg <= res_passed_next;
        res_depth_reg  <= res_depth_next;
        res_level_reg  <= res_level_next;
        out_passed_reg <= out_passed_next;
        out_depth_reg  <= out_depth_next;
        out_level_reg  <= out_level_next;
    end

    assign cmd.ready      = (state_reg == S_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.passed     = out_passed_reg;
    assign res.node_depth = out_depth_reg;
    assign res.node_level = out_level_reg;

    `HZP_ASSERT_IMPLY(a_no_rw_clash, clk, rst_n, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "read and write hit the same quad")
    `HZP_ASSERT_NEXT(a_climb_steps_up, clk, rst_n, state_reg == S_CLIMB && state_next == S_CLIMB, lvl_reg == $past(lvl_reg) - 1'b1, "climb skipped a level")
    `HZP_ASSERT_NEXT(a_root_takes_min, clk, rst_n, state_reg == S_ROOT, root_reg == $past(m_reg), "root missed the quad minimum")
    `HZP_ASSERT_NEXT(a_result_held, clk, rst_n, state_reg == S_DONE && out_valid_reg && !res.ready, state_reg == S_DONE, "pending result dropped")

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hzp_pkg::*;

    localparam int SIDE_LOG2   = SIDE_LOG2_DEF;
    localparam int SIDE        = 1 << SIDE_LOG2;
    localparam int NODES       = ((1 << (2 * (SIDE_LOG2 + 1))) - 1) / 3;
    localparam int TOTAL_ITEMS = 550;
    localparam int HOLD_CYCLES = 400;
    localparam int PRINT_CAP   = 100;
    localparam int SETTLE      = 3 * (SIDE_LOG2 + 4);

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam logic signed [DEPTH_W-1:0] FAR     = {1'b1, {(DEPTH_W-1){1'b0}}};
    localparam logic signed [DEPTH_W-1:0] NEAREST = {1'b0, {(DEPTH_W-1){1'b1}}};

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic [COORD_W-1:0]         x_first;
        logic [COORD_W-1:0]         y_first;
        logic [COORD_W-1:0]         x_last;
        logic [COORD_W-1:0]         y_last;
        logic signed [DEPTH_W-1:0]  depth;
    } zcmd_t;

    typedef struct packed {
        logic                       passed;
        logic signed [DEPTH_W-1:0]  node_depth;
        logic [LEVEL_W-1:0]         node_level;
    } zres_t;

    typedef struct {
        zcmd_t c;
        bit    known;
        zres_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hzp_cmd_if cmd ();
    hzp_res_if res ();

    hierarchical_z_pyramid dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the depth pyramid, level by level from the root
    logic signed [DEPTH_W-1:0] pyr [NODES];
    zres_t expected_results [$];

    int send_gap_pct = 23;
    int recv_gap_pct = 83;
    int hold_req = 0;

    int mismatches = 0;
    int items_sent = 0;
    int n_checked = 0;
    int n_write = 0;
    int n_stored = 0;
    int n_query = 0;
    int n_occluded = 0;
    int n_clear = 0;
    int n_spare = 0;
    int deepest_climb = SIDE_LOG2;

    // Far value everywhere; an item in flight reads the far pixel until a write beats it
    dir_row_t directed [22] = '{
        '{'{OP_QUERY, 9'd0, 9'd0, 9'd511, 9'd511, 24'sd0}, 1'b1, '{1'b1, FAR, 4'd0}},
        '{'{OP_QUERY, 9'd5, 9'd7, 9'd5, 9'd7, FAR}, 1'b1, '{1'b0, FAR, 4'd9}},
        '{'{OP_WRITE, 9'd0, 9'd0, 9'd511, 9'd511, FAR}, 1'b1, '{1'b0, FAR, 4'd9}},
        '{'{OP_WRITE, 9'd511, 9'd511, 9'd0, 9'd0, NEAREST}, 1'b1, '{1'b1, NEAREST, 4'd9}},
        '{'{OP_WRITE, 9'd511, 9'd511, 9'd0, 9'd0, 24'sd5}, 1'b1, '{1'b0, NEAREST, 4'd9}},
        '{'{OP_WRITE, 9'd0, 9'd0, 9'd0, 9'd0, 24'sd0}, 1'b0, '0},
        '{'{OP_WRITE, 9'd1, 9'd0, 9'd0, 9'd0, 24'sd100}, 1'b0, '0},
        '{'{OP_WRITE, 9'd0, 9'd1, 9'd0, 9'd0, 24'sd200}, 1'b0, '0},
        '{'{OP_WRITE, 9'd1, 9'd1, 9'd0, 9'd0, 24'sd300}, 1'b0, '0},
        '{'{OP_QUERY, 9'd0, 9'd0, 9'd1, 9'd1, 24'sd0}, 1'b0, '0},
        '{'{OP_QUERY, 9'd1, 9'd1, 9'd0, 9'd0, 24'sd1}, 1'b0, '0},
        '{'{OP_WRITE, 9'd0, 9'd0, 9'd0, 9'd0, -24'sd50}, 1'b0, '0},
        '{'{OP_WRITE, 9'd1, 9'd1, 9'd0, 9'd0, 24'sd400}, 1'b0, '0},
        '{'{OP_QUERY, 9'd0, 9'd0, 9'd0, 9'd0, 24'sd0}, 1'b0, '0},
        '{'{OP_QUERY, 9'd510, 9'd0, 9'd511, 9'd511, 24'sd7}, 1'b0, '0},
        '{'{OP_QUERY, 9'd256, 9'd255, 9'd256, 9'd256, -24'sd1}, 1'b0, '0},
        '{'{OP_WRITE, 9'd256, 9'd256, 9'd0, 9'd0, FAR + 24'sd1}, 1'b1,
          '{1'b1, FAR + 24'sd1, 4'd9}},
        '{'{OP_SPARE, 9'd511, 9'd511, 9'd511, 9'd511, -24'sd1}, 1'b1, '{1'b0, 24'sd0, 4'd0}},
        '{'{OP_CLEAR, 9'd0, 9'd0, 9'd0, 9'd0, 24'sd0}, 1'b1, '{1'b1, FAR, 4'd0}},
        '{'{OP_QUERY, 9'd511, 9'd511, 9'd511, 9'd511, NEAREST}, 1'b1, '{1'b1, FAR, 4'd9}},
        '{'{OP_WRITE, 9'd0, 9'd0, 9'd0, 9'd0, NEAREST}, 1'b1, '{1'b1, NEAREST, 4'd9}},
        '{'{OP_QUERY, 9'd0, 9'd0, 9'd0, 9'd0, NEAREST}, 1'b1, '{1'b0, NEAREST, 4'd9}}
    };

    function automatic int node_at(input int lvl, input int x, input int y);
        return ((1 << (2 * lvl)) - 1) / 3 + (y << lvl) + x;
    endfunction

    function automatic void fill_far();
        foreach (pyr[n])
            pyr[n] = FAR;
    endfunction

    function automatic void queue_result(input zres_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic zcmd_t mk_cmd(input logic [OP_W-1:0] op, input int xf, input int yf,
                                     input int xl, input int yl,
                                     input logic signed [DEPTH_W-1:0] d);
        zcmd_t c;
        c.op      = op;
        c.x_first = COORD_W'(xf);
        c.y_first = COORD_W'(yf);
        c.x_last  = COORD_W'(xl);
        c.y_last  = COORD_W'(yl);
        c.depth   = d;
        return c;
    endfunction

    // Apply one command to the shadow pyramid and return the result it should produce
    function automatic zres_t run_pyramid_op(input zcmd_t c);
        zres_t r;
        int x, y, l, leaf, cx, cy, parent, lo_x, lo_y, diff, span;
        logic signed [DEPTH_W-1:0] m;
        r = '0;
        case (c.op)
            OP_WRITE:
            begin
                n_write++;
                leaf = node_at(SIDE_LOG2, int'(c.x_first), int'(c.y_first));
                r.node_level = LEVEL_W'(SIDE_LOG2);
                if (c.depth > pyr[leaf])
                begin
                    n_stored++;
                    pyr[leaf] = c.depth;
                    r.passed = 1'b1;
                    x = int'(c.x_first);
                    y = int'(c.y_first);
                    for (l = SIDE_LOG2; l > 0; l--)
                    begin
                        cx = (x >> 1) << 1;
                        cy = (y >> 1) << 1;
                        m = pyr[node_at(l, cx, cy)];
                        if (pyr[node_at(l, cx + 1, cy)] < m) m = pyr[node_at(l, cx + 1, cy)];
                        if (pyr[node_at(l, cx, cy + 1)] < m) m = pyr[node_at(l, cx, cy + 1)];
                        if (pyr[node_at(l, cx + 1, cy + 1)] < m)
                            m = pyr[node_at(l, cx + 1, cy + 1)];
                        parent = node_at(l - 1, x >> 1, y >> 1);
                        // stop at the first ancestor that keeps its value
                        if (pyr[parent] == m)
                            break;
                        pyr[parent] = m;
                        if (l - 1 < deepest_climb)
                            deepest_climb = l - 1;
                        x = x >> 1;
                        y = y >> 1;
                    end
                end
                r.node_depth = pyr[leaf];
            end
            OP_QUERY:
            begin
                n_query++;
                lo_x = (c.x_first < c.x_last) ? int'(c.x_first) : int'(c.x_last);
                lo_y = (c.y_first < c.y_last) ? int'(c.y_first) : int'(c.y_last);
                diff = int'(c.x_first ^ c.x_last) | int'(c.y_first ^ c.y_last);
                span = 0;
                while (diff != 0)
                begin
                    span++;
                    diff = diff >> 1;
                end
                r.node_level = LEVEL_W'(SIDE_LOG2 - span);
                r.node_depth = pyr[node_at(SIDE_LOG2 - span, lo_x >> span, lo_y >> span)];
                r.passed = (r.node_depth >= c.depth) ? 1'b0 : 1'b1;
                if (!r.passed)
                    n_occluded++;
            end
            OP_CLEAR:
            begin
                n_clear++;
                fill_far();
                r.passed = 1'b1;
                r.node_depth = FAR;
            end
            default:
                n_spare++;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic issue(input zcmd_t c, input bit known, input zres_t typed);
        zres_t model;
        bit    acc;
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid   <= 1'b1;
        cmd.op      <= c.op;
        cmd.x_first <= c.x_first;
        cmd.y_first <= c.y_first;
        cmd.x_last  <= c.x_last;
        cmd.y_last  <= c.y_last;
        cmd.depth   <= c.depth;
        // ready only moves at rising edges, so its mid-cycle value decides the transfer
        do
        begin
            @(negedge clk);
            acc = cmd.ready;
            @(posedge clk);
        end
        while (!acc);
        model = run_pyramid_op(c);
        queue_result(known ? typed : model);
        items_sent++;
    endtask

    // Hold the command side until every outstanding result has been taken
    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random back-pressure, one long hold on request, and the checker
    initial
    begin
        int    hold_left;
        int    holds_seen;
        bit    took;
        zres_t got;
        zres_t want;
        hold_left = 0;
        holds_seen = 0;
        res.ready <= 1'b0;
        forever
        begin
            // sample mid-cycle, where valid, ready and the payload are settled
            @(negedge clk);
            took = rst_n && res.valid === 1'b1 && res.ready === 1'b1;
            got.passed     = res.passed;
            got.node_depth = res.node_depth;
            got.node_level = res.node_level;
            @(posedge clk);
            if (took)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result with nothing outstanding: %0b %0d %0d",
                                              got.passed, got.node_depth, got.node_level));
                else
                begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (got.passed !== want.passed || got.node_depth !== want.node_depth ||
                        got.node_level !== want.node_level)
                        report_mismatch($sformatf(
                            "result %0d: passed %0b/%0b depth %0d/%0d level %0d/%0d (got/want)",
                            n_checked, got.passed, want.passed, got.node_depth,
                            want.node_depth, got.node_level, want.node_level));
                end
            end
            if (hold_req != holds_seen)
            begin
                holds_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    initial
    begin
        int i, j, t, pick, size_log, span_px, bx, by, xa, ya, xb, yb, q, low_mark;
        int clears_left, phase;
        int order [$];
        logic signed [DEPTH_W-1:0] base, d;

        cmd.valid   <= 1'b0;
        cmd.op      <= OP_WRITE;
        cmd.x_first <= '0;
        cmd.y_first <= '0;
        cmd.x_last  <= '0;
        cmd.y_last  <= '0;
        cmd.depth   <= '0;
        fill_far();
        clears_left = 2;
        phase = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[r])
            issue(directed[r].c, directed[r].known, directed[r].want);

        while (items_sent < TOTAL_ITEMS)
        begin
            if (phase == 0 && items_sent >= TOTAL_ITEMS / 3)
            begin
                drain();
                phase = 1;
                send_gap_pct = 83;
                recv_gap_pct = 23;
            end
            else if (phase == 1 && items_sent >= 2 * TOTAL_ITEMS / 3)
            begin
                drain();
                phase = 2;
                send_gap_pct = 0;
                recv_gap_pct = 0;
                // stall results for a long stretch while commands keep coming
                hold_req++;
            end

            pick = $urandom_range(99);
            if (pick < 3 && clears_left > 0)
            begin
                clears_left--;
                issue(mk_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                             DEPTH_W'($urandom)), 1'b0, '0);
            end
            else if (pick < 6)
                issue(mk_cmd(OP_SPARE, $urandom, $urandom, $urandom, $urandom,
                             DEPTH_W'($urandom)), 1'b0, '0);
            else if (pick < 60)
            begin
                // fill an aligned square so that its ancestors get refreshed, then probe it
                size_log = ($urandom_range(9) == 0) ? 3 : int'($urandom_range(2, 1));
                span_px = 1 << size_log;
                bx = int'($urandom_range(SIDE - 1)) & ~(span_px - 1);
                by = int'($urandom_range(SIDE - 1)) & ~(span_px - 1);
                order.delete();
                for (i = 0; i < span_px * span_px; i++)
                    order = {order, i};
                for (i = order.size() - 1; i > 0; i--)
                begin
                    j = int'($urandom_range(i));
                    t = order[i];
                    order[i] = order[j];
                    order[j] = t;
                end
                base = DEPTH_W'($urandom);
                low_mark = int'(NEAREST);
                foreach (order[k])
                begin
                    d = base + DEPTH_W'($urandom_range(255));
                    if ($urandom_range(3) == 0)
                        d = DEPTH_W'($urandom);
                    if (int'(d) < low_mark)
                        low_mark = int'(d);
                    issue(mk_cmd(OP_WRITE, bx + order[k] % span_px, by + order[k] / span_px,
                                 $urandom, $urandom, d), 1'b0, '0);
                end
                repeat ($urandom_range(3, 1))
                begin
                    if ($urandom_range(1) == 0)
                    begin
                        xa = bx;
                        ya = by;
                        xb = bx + span_px - 1;
                        yb = by + span_px - 1;
                    end
                    else
                    begin
                        xa = bx + int'($urandom_range(span_px - 1));
                        ya = by + int'($urandom_range(span_px - 1));
                        xb = bx + int'($urandom_range(span_px - 1));
                        yb = by + int'($urandom_range(span_px - 1));
                    end
                    q = low_mark + int'($urandom_range(2)) - 1;
                    if (q < int'(FAR))
                        q = int'(FAR);
                    if (q > int'(NEAREST))
                        q = int'(NEAREST);
                    d = DEPTH_W'(q);
                    if ($urandom_range(4) == 0)
                        d = DEPTH_W'($urandom);
                    if ($urandom_range(1) == 0)
                        issue(mk_cmd(OP_QUERY, xa, ya, xb, yb, d), 1'b0, '0);
                    else
                        issue(mk_cmd(OP_QUERY, xb, yb, xa, ya, d), 1'b0, '0);
                end
            end
            else
                issue(mk_cmd(($urandom_range(1) == 0) ? OP_WRITE : OP_QUERY, $urandom,
                             $urandom, $urandom, $urandom, DEPTH_W'($urandom)), 1'b0, '0);
        end

        drain();
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d writes (%0d stored), %0d queries (%0d occluded), %0d clears,",
                 n_write, n_stored, n_query, n_occluded, n_clear);
        $display("%0d unused-op items; %0d results compared, refresh reached level %0d.",
                 n_spare, n_checked, deepest_climb);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timed out with %0d results outstanding.", expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
